### rtl/core/lph_pkg.sv
// Shared types and constants for the looping playhead accumulator.
// No dependencies; every module of the block imports this package.
package lph_pkg;

  localparam int INDEX_BITS     = 16;
  localparam int FRACTION_BITS  = 16;
  localparam int POS_BITS       = INDEX_BITS + FRACTION_BITS;
  localparam int PHASE_BITS     = FRACTION_BITS + 1;
  localparam int STEP_BITS      = FRACTION_BITS + 1;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [PHASE_BITS-1:0] ONE_ROW = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PAUSED         = 3'd0,
    REG_LOOP_ENABLE    = 3'd1,
    REG_LOOP_START     = 3'd2,
    REG_LOOP_END       = 3'd3,
    REG_PHASE_STEP     = 3'd4,
    REG_ROW_COUNT      = 3'd5,
    REG_INTERPOLATE_ON = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_SEEK = 1'b1
  } action_t;

  typedef struct packed {
    logic                  paused;
    logic                  loop_enable;
    logic [POS_BITS-1:0]   loop_start;
    logic [POS_BITS-1:0]   loop_end;
    logic [STEP_BITS-1:0]  phase_step;
    logic [INDEX_BITS-1:0] row_count;
    logic                  interpolate_on;
  } cfg_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]    row_index;
    logic [INDEX_BITS-1:0]    next_row_index;
    logic [FRACTION_BITS-1:0] fraction;
    logic                     refresh_row;
    logic                     row_advanced;
    logic [POS_BITS-1:0]      reported_position;
  } result_t;

endpackage

### rtl/core/lph_cfg_regs.sv
// Configuration register file of the looping playhead accumulator.
// Depends on lph_pkg for the register indexes and the cfg_t bundle.
module lph_cfg_regs
  import lph_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.paused         <= 1'b1;
      cfg.loop_enable    <= 1'b0;
      cfg.loop_start     <= '0;
      cfg.loop_end       <= '0;
      cfg.phase_step     <= '0;
      cfg.row_count      <= '0;
      cfg.interpolate_on <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAUSED:         cfg.paused         <= cfg_data[0];
        REG_LOOP_ENABLE:    cfg.loop_enable    <= cfg_data[0];
        REG_LOOP_START:     cfg.loop_start     <= cfg_data[POS_BITS-1:0];
        REG_LOOP_END:       cfg.loop_end       <= cfg_data[POS_BITS-1:0];
        REG_PHASE_STEP:     cfg.phase_step     <= cfg_data[STEP_BITS-1:0];
        REG_ROW_COUNT:      cfg.row_count      <= cfg_data[INDEX_BITS-1:0];
        REG_INTERPOLATE_ON: cfg.interpolate_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/lph_step_unit.sv
// Playhead state registers and the combinational tick/seek update logic.
// Depends on lph_pkg for widths, the action codes and the cfg_t/result_t bundles.
module lph_step_unit
  import lph_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                action,
  input  logic [POS_BITS-1:0] seek_position,
  input  cfg_t                cfg,
  output logic                result_load,
  output result_t             result
);

  logic [INDEX_BITS-1:0] row_pointer, row_pointer_next;
  logic [PHASE_BITS-1:0] phase_fraction, phase_fraction_next;
  logic                  row_stale, row_stale_next;

  logic                     carry;
  logic [INDEX_BITS-1:0]    row_inc, row_c, row_l, row_rep, seek_row, follow_inc;
  logic [FRACTION_BITS-1:0] frac_l;
  logic [POS_BITS-1:0]      pos_c;
  logic                     jump, stale_l, refresh;
  logic [PHASE_BITS-1:0]    step_c;

  always_comb begin
    carry    = phase_fraction[FRACTION_BITS];
    row_inc  = row_pointer + INDEX_BITS'(1);
    row_c    = row_pointer;
    if (carry) begin
      row_c = (row_inc >= cfg.row_count) ? '0 : row_inc;
    end
    pos_c = {row_c, phase_fraction[FRACTION_BITS-1:0]};
    jump  = cfg.loop_enable && (cfg.loop_start != cfg.loop_end) &&
            ((pos_c > cfg.loop_end) || (pos_c < cfg.loop_start));
    row_l  = jump ? cfg.loop_start[POS_BITS-1:FRACTION_BITS] : row_c;
    frac_l = jump ? cfg.loop_start[FRACTION_BITS-1:0] : phase_fraction[FRACTION_BITS-1:0];
    stale_l = row_stale | carry | jump | cfg.interpolate_on;
    refresh = stale_l && (cfg.row_count != '0);
    step_c  = (cfg.phase_step > STEP_BITS'(ONE_ROW)) ? ONE_ROW
                                                      : PHASE_BITS'(cfg.phase_step);
    seek_row = seek_position[POS_BITS-1:FRACTION_BITS];

    row_pointer_next    = row_pointer;
    phase_fraction_next = phase_fraction;
    row_stale_next      = row_stale;
    result_load         = 1'b0;
    row_rep             = row_pointer;
    result.fraction          = '0;
    result.refresh_row       = 1'b0;
    result.row_advanced      = 1'b0;
    result.reported_position = '0;

    if (accept) begin
      case (action_t'(action))
        ACT_SEEK: begin
          if (seek_row != row_pointer) begin
            row_stale_next = 1'b1;
          end
          row_pointer_next    = seek_row;
          phase_fraction_next = {1'b0, seek_position[FRACTION_BITS-1:0]};
        end
        ACT_TICK: begin
          result_load = 1'b1;
          if (cfg.paused) begin
            result.reported_position = {row_pointer, {FRACTION_BITS{1'b0}}} +
                                       POS_BITS'(phase_fraction);
          end else begin
            row_rep                  = row_l;
            row_pointer_next         = row_l;
            phase_fraction_next      = {1'b0, frac_l} + step_c;
            row_stale_next           = stale_l && !refresh;
            result.refresh_row       = refresh;
            result.row_advanced      = carry;
            result.reported_position = {row_l, frac_l};
          end
          result.fraction = result.reported_position[FRACTION_BITS-1:0];
        end
        default: ;
      endcase
    end

    follow_inc            = row_rep + INDEX_BITS'(1);
    result.row_index      = row_rep;
    result.next_row_index = (follow_inc >= cfg.row_count) ? '0 : follow_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pointer    <= '0;
      phase_fraction <= '0;
      row_stale      <= 1'b0;
    end else begin
      row_pointer    <= row_pointer_next;
      phase_fraction <= phase_fraction_next;
      row_stale      <= row_stale_next;
    end
  end

  a_seek_sets_position: assert property (@(posedge clk) disable iff (rst)
    accept && (action == ACT_SEEK) |=>
      (row_pointer == $past(seek_position[POS_BITS-1:FRACTION_BITS])) &&
      !phase_fraction[FRACTION_BITS])
    else $error("seek did not land on the requested position");

  a_refresh_clears_stale: assert property (@(posedge clk) disable iff (rst)
    accept && (action == ACT_TICK) && !cfg.paused && (cfg.row_count != '0) |=>
      !row_stale)
    else $error("stale mark survived a running tick with data loaded");

  a_paused_holds: assert property (@(posedge clk) disable iff (rst)
    accept && (action == ACT_TICK) && cfg.paused |=>
      $stable(row_pointer) && $stable(phase_fraction) && $stable(row_stale))
    else $error("paused tick moved the playhead");

  a_advance_needs_carry: assert property (@(posedge clk) disable iff (rst)
    result_load && result.row_advanced |-> phase_fraction[FRACTION_BITS] && !cfg.paused)
    else $error("row advance flagged without a whole-row carry");

endmodule

### rtl/core/lph_result_reg.sv
// Output register of the looping playhead accumulator: holds one result beat.
// Depends on lph_pkg for the result_t bundle.
module lph_result_reg
  import lph_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t result_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

### rtl/core/looping_playhead_accumulator.sv
// Looping playhead accumulator: one tick or seek beat is taken every clock cycle
// while the output register is empty or being drained in that same cycle. A tick's
// result beat is on the output in the cycle after acceptance, computed in one pass
// from the playhead registers (carry, wrap, loop check, phase add); a seek beat
// moves the playhead and gives no result. Configuration writes are registered.
// Depends on lph_pkg, lph_cfg_regs, lph_step_unit and lph_result_reg.
module looping_playhead_accumulator
  import lph_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      action,
  input  logic [POS_BITS-1:0]       seek_position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [INDEX_BITS-1:0]     row_index,
  output logic [INDEX_BITS-1:0]     next_row_index,
  output logic [FRACTION_BITS-1:0]  fraction,
  output logic                      refresh_row,
  output logic                      row_advanced,
  output logic [POS_BITS-1:0]       reported_position
);

  cfg_t    cfg;
  result_t step_result;
  result_t held_result;
  logic    result_load;
  logic    accept;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  lph_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  lph_step_unit u_step (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .action        (action),
    .seek_position (seek_position),
    .cfg           (cfg),
    .result_load   (result_load),
    .result        (step_result)
  );

  lph_result_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (result_load),
    .result_in  (step_result),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .result_out (held_result)
  );

  assign row_index         = held_result.row_index;
  assign next_row_index    = held_result.next_row_index;
  assign fraction          = held_result.fraction;
  assign refresh_row       = held_result.refresh_row;
  assign row_advanced      = held_result.row_advanced;
  assign reported_position = held_result.reported_position;

endmodule
